@@ src/stid_pkg.sv @@
// Shared types and constants for the sequential tone identity decoder.
// No dependencies; used by every module in src.
`default_nettype none

package stid_pkg;

	localparam int NUM_TONES   = 17;
	localparam int CLASS_W     = 5;
	localparam int FREQ_W      = 16;
	localparam int TOL_W       = 10;
	localparam int RUN_W       = 12;
	localparam int SIL_W       = 16;
	localparam int DIGIT_W     = 4;
	localparam int OUT_DIGITS  = 6;
	localparam int COUNT_W     = 3;
	localparam int OUT_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int ID_DIGITS_DEF   = 6;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [CLASS_W-1:0] CLASS_IDLE   = 5'd0;
	localparam logic [CLASS_W-1:0] CLASS_REPEAT = 5'd1;
	localparam logic [CLASS_W-1:0] CLASS_DIGIT0 = 5'd2;
	localparam logic [CLASS_W-1:0] CLASS_NONE   = 5'd17;

	localparam logic [DIGIT_W-1:0] CODE_REPEAT = 4'd15;

	localparam logic [RUN_W-1:0] RUN_MAX     = 12'd4095;
	localparam logic [SIL_W-1:0] SILENCE_MAX = 16'd65535;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_RUN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_RUN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd2;

	localparam logic [RUN_W-1:0] DETECT_RUN_RST  = 12'd200;
	localparam logic [SIL_W-1:0] TIMEOUT_RUN_RST = 16'd4000;
	localparam logic [TOL_W-1:0] TOLERANCE_RST   = 10'd150;

	// Tone centers in 0.1 Hz: idle, repeat, then digits 0..E
	localparam logic [FREQ_W-1:0] TONE_TABLE [NUM_TONES] = '{
		16'd11531, 16'd10629, 16'd9798, 16'd9031, 16'd8325, 16'd7674,
		16'd7074,  16'd6520,  16'd6010, 16'd5540, 16'd5107, 16'd4708,
		16'd4339,  16'd4000,  16'd3687, 16'd3399, 16'd3133
	};

	// One classified sample handed from front to back
	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic               det;
	} event_t;

endpackage

`default_nettype wire

@@ src/stid_front.sv @@
// Front end: classifies each sample against the tone table and tracks the run length.
// Depends on stid_pkg.
`default_nettype none

module stid_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire logic [stid_pkg::FREQ_W-1:0]     freq,
	input  wire logic [stid_pkg::RUN_W-1:0]      detect_run,
	input  wire logic [stid_pkg::TOL_W-1:0]      tolerance,
	output stid_pkg::event_t                     ev
);

	logic [stid_pkg::CLASS_W-1:0] last_class_q;
	logic [stid_pkg::RUN_W-1:0]   run_q;
	logic [stid_pkg::CLASS_W-1:0] cls;
	logic [stid_pkg::RUN_W-1:0]   run_base;
	logic [stid_pkg::RUN_W-1:0]   run_n;
	logic                         det;

	// Parallel window compare; walk downward so the lowest matching entry wins
	always_comb begin
		logic [stid_pkg::FREQ_W:0] f_ext;
		logic [stid_pkg::FREQ_W:0] t_ext;
		logic [stid_pkg::FREQ_W:0] lo;
		logic [stid_pkg::FREQ_W:0] hi;
		f_ext = {1'b0, freq};
		t_ext = (stid_pkg::FREQ_W+1)'(tolerance);
		cls   = stid_pkg::CLASS_NONE;
		for (int k = stid_pkg::NUM_TONES - 1; k >= 0; k--) begin
			lo = {1'b0, stid_pkg::TONE_TABLE[k]} - t_ext;
			hi = {1'b0, stid_pkg::TONE_TABLE[k]} + t_ext;
			if (f_ext >= lo && f_ext <= hi) begin
				cls = stid_pkg::CLASS_W'(k);
			end
		end
	end

	// Restart on class change, saturate at the top
	always_comb begin
		run_base = (cls != last_class_q) ? '0 : run_q;
		run_n    = run_base;
		det      = 1'b0;
		if (run_base < stid_pkg::RUN_MAX) begin
			run_n = run_base + 1'b1;
			det   = (run_n == detect_run);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_class_q <= stid_pkg::CLASS_NONE;
			run_q        <= '0;
		end else if (accept) begin
			last_class_q <= cls;
			run_q        <= run_n;
		end
	end

	assign ev.cls = cls;
	assign ev.det = det;

endmodule

`default_nettype wire

@@ src/stid_evq.sv @@
// Short event queue between the classifying front and the reception back end.
// Depends on stid_pkg.
`default_nettype none

module stid_evq #(
	parameter int DEPTH = stid_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire stid_pkg::event_t push_ev,
	output logic            full,
	input  wire logic       pop,
	output stid_pkg::event_t pop_ev,
	output logic            not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	stid_pkg::event_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_ev    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/stid_back.sv @@
// Back end: reception state, digit store, silence timeout and the result register.
// Depends on stid_pkg.
`default_nettype none

module stid_back #(
	parameter int ID_DIGITS = stid_pkg::ID_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          ev_avail,
	input  wire stid_pkg::event_t              ev,
	output logic                               ev_pop,
	input  wire logic [stid_pkg::SIL_W-1:0]    timeout_run,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [stid_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int IDX_W = $clog2(ID_DIGITS + 1);

	logic                          rcv_q;
	logic [IDX_W-1:0]              idx_q;
	logic [stid_pkg::SIL_W-1:0]    sil_q;
	logic [stid_pkg::DIGIT_W-1:0]  store_q [ID_DIGITS];

	logic                          rcv_n;
	logic [IDX_W-1:0]              idx_n;
	logic [stid_pkg::SIL_W-1:0]    sil_n;
	logic                          wr;
	logic                          emit;
	logic [stid_pkg::DIGIT_W-1:0]  code;
	logic [3:0]                    idx_ext;
	logic [stid_pkg::DIGIT_W-1:0]  view [stid_pkg::OUT_DIGITS];
	logic [stid_pkg::DIGIT_W-1:0]  res_digit [stid_pkg::OUT_DIGITS];

	// Take an event whenever the result register can accept a new result
	assign ev_pop = ev_avail && (!m_tvalid || m_tready);

	always_comb begin
		logic [stid_pkg::CLASS_W-1:0] cls_off;
		logic                         first_rep;
		rcv_n     = rcv_q;
		idx_n     = idx_q;
		sil_n     = sil_q;
		wr        = 1'b0;
		emit      = 1'b0;
		cls_off   = ev.cls - stid_pkg::CLASS_DIGIT0;
		code      = (ev.cls == stid_pkg::CLASS_REPEAT) ? stid_pkg::CODE_REPEAT
		                                                : cls_off[stid_pkg::DIGIT_W-1:0];
		first_rep = (idx_q == '0) ? (code == stid_pkg::CODE_REPEAT)
		                          : (store_q[0] == stid_pkg::CODE_REPEAT);
		if (ev.cls == stid_pkg::CLASS_IDLE) begin
			if (ev.det) begin
				rcv_n = 1'b1;
				idx_n = '0;
				sil_n = '0;
			end
		end else if (ev.cls == stid_pkg::CLASS_NONE) begin
			if (rcv_q && ev.det) begin
				rcv_n = 1'b0;
			end
		end else if (rcv_q && ev.det && idx_q < IDX_W'(ID_DIGITS)) begin
			wr    = 1'b1;
			idx_n = idx_q + 1'b1;
			sil_n = '0;
			if (idx_n == IDX_W'(ID_DIGITS) || first_rep) begin
				emit  = 1'b1;
				rcv_n = 1'b0;
			end
		end
		// Silence timeout once at least one digit is stored
		if (rcv_n && idx_n != '0 && sil_n != stid_pkg::SILENCE_MAX) begin
			sil_n = sil_n + 1'b1;
			if (sil_n == timeout_run) begin
				rcv_n = 1'b0;
			end
		end
	end

	// Result digits as they stand after this event's write
	for (genvar j = 0; j < stid_pkg::OUT_DIGITS; j++) begin : g_view
		if (j < ID_DIGITS) begin : g_used
			assign view[j] = (wr && idx_q == IDX_W'(j)) ? code : store_q[j];
			assign res_digit[j] = (IDX_W'(j) < idx_n) ? view[j] : '0;
		end else begin : g_unused
			assign view[j]      = '0;
			assign res_digit[j] = view[j];
		end
	end

	assign idx_ext = 4'(idx_n);

	always_ff @(posedge clk) begin
		for (int e = 0; e < ID_DIGITS; e++) begin
			if (ev_pop && wr && idx_q == IDX_W'(e)) begin
				store_q[e] <= code;
			end
		end
		if (ev_pop && emit) begin
			m_tdata <= {5'b0, idx_ext[stid_pkg::COUNT_W-1:0],
			            res_digit[5], res_digit[4], res_digit[3],
			            res_digit[2], res_digit[1], res_digit[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q    <= 1'b0;
			idx_q    <= '0;
			sil_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (ev_pop) begin
				rcv_q <= rcv_n;
				idx_q <= idx_n;
				sil_q <= sil_n;
			end
			if (ev_pop && emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/sequential_tone_id_decoder.sv @@
// Top level of the sequential tone identity decoder: config registers, front, queue, back.
// Depends on stid_pkg, stid_front, stid_evq and stid_back.
`default_nettype none

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready    | s_tdata: freq_tenth_hz
//  m_      | out       | m_tvalid / m_tready    | m_tdata: id_digit_0..5, digit_count
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data (write only)
//
//  One sample is accepted per cycle while the queue has room. The front classifies and
//  counts the run in the accept cycle and pushes an event into a QUEUE_DEPTH entry queue;
//  the back end pops one event per cycle into the result register when it can take one.
//  A stalled output holds the result register; the queue then fills and s_tready drops.
//  Reset clears all control state; the configuration registers return to their defaults.
//  Configuration writes are always taken (cfg_ready is high) and belong to idle periods.

module sequential_tone_id_decoder #(
	parameter int ID_DIGITS   = stid_pkg::ID_DIGITS_DEF,
	parameter int QUEUE_DEPTH = stid_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// sample stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [stid_pkg::FREQ_W-1:0]        s_tdata,   // [15:0] freq_tenth_hz
	// identity stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [3:0] id_digit_0, [7:4] id_digit_1, [11:8] id_digit_2, [15:12] id_digit_3,
	// [19:16] id_digit_4, [23:20] id_digit_5, [26:24] digit_count, [31:27] zero
	output logic [stid_pkg::OUT_DATA_W-1:0]         m_tdata,
	// configuration writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [stid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [stid_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [stid_pkg::RUN_W-1:0] detect_run_q;
	logic [stid_pkg::SIL_W-1:0] timeout_run_q;
	logic [stid_pkg::TOL_W-1:0] tolerance_q;

	stid_pkg::event_t front_ev;
	stid_pkg::event_t back_ev;
	logic             q_full;
	logic             q_avail;
	logic             q_pop;
	logic             accept;

	assign cfg_ready = 1'b1;

	// Hold each register; write it with the low bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_run_q  <= stid_pkg::DETECT_RUN_RST;
			timeout_run_q <= stid_pkg::TIMEOUT_RUN_RST;
			tolerance_q   <= stid_pkg::TOLERANCE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				stid_pkg::REG_DETECT_RUN: begin
					detect_run_q <= cfg_data[stid_pkg::RUN_W-1:0];
				end
				stid_pkg::REG_TIMEOUT_RUN: begin
					timeout_run_q <= cfg_data[stid_pkg::SIL_W-1:0];
				end
				stid_pkg::REG_TOLERANCE: begin
					tolerance_q <= cfg_data[stid_pkg::TOL_W-1:0];
				end
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	// Accept a sample whenever the queue has room
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	stid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.freq       (s_tdata),
		.detect_run (detect_run_q),
		.tolerance  (tolerance_q),
		.ev         (front_ev)
	);

	stid_evq #(
		.DEPTH (QUEUE_DEPTH)
	) u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_ev   (front_ev),
		.full      (q_full),
		.pop       (q_pop),
		.pop_ev    (back_ev),
		.not_empty (q_avail)
	);

	stid_back #(
		.ID_DIGITS (ID_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_avail    (q_avail),
		.ev          (back_ev),
		.ev_pop      (q_pop),
		.timeout_run (timeout_run_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire

@@ test/sequential_tone_id_decoder_tb.sv @@
// Self-checking bench for the sequential tone identity decoder: drives tone samples and
// register writes, predicts every identity in step with the stream and compares each one.
// Depends on stid_pkg and sequential_tone_id_decoder from src.
module sequential_tone_id_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stid_pkg::*;

	localparam int ID_LEN    = ID_DIGITS_DEF;
	localparam int LONG_HOLD = 32;      // one tone held well past its detect point
	localparam int STALL_LEN = 400;     // output hold-off, long enough to back up the input
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// which side takes random gaps
	typedef enum int {RX_SLOW, TX_SLOW, NO_IDLE} idle_mode_e;

	// one identity as it leaves the block
	typedef struct packed {
		logic [COUNT_W-1:0]                 count;
		logic [OUT_DIGITS-1:0][DIGIT_W-1:0] digit;
	} ident_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [FREQ_W-1:0]     s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sequential_tone_id_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Decoder shadow: register copies and control state, advanced once per accepted sample
	logic [RUN_W-1:0]   cur_detect = DETECT_RUN_RST;
	logic [SIL_W-1:0]   cur_timeout = TIMEOUT_RUN_RST;
	logic [TOL_W-1:0]   cur_tol = TOLERANCE_RST;
	logic [CLASS_W-1:0] last_cls = CLASS_NONE;
	logic [RUN_W-1:0]   run_cnt = '0;
	logic               rx_active = 1'b0;
	logic [COUNT_W-1:0] dig_idx = '0;
	logic [DIGIT_W-1:0] dig_store [ID_LEN];
	logic [SIL_W-1:0]   sil_cnt = '0;

	logic [FREQ_W-1:0] sample_q [$];   // samples waiting for the driver
	ident_t            ident_q [$];    // identities predicted but not yet seen

	idle_mode_e idle_mode = RX_SLOW;
	logic       rx_hold = 1'b0;
	bit         pressure_go = 1'b0;
	int         queued = 0;
	int         samples_in = 0;
	int         idents_out = 0;
	int         reg_writes = 0;
	int         errors = 0;
	ident_t     id_pred, id_want, id_got;

	// First table entry whose window holds the frequency wins; scan backward so it lands last
	function automatic logic [CLASS_W-1:0] tone_class(input logic [FREQ_W-1:0] freq);
		int t;
		logic [CLASS_W-1:0] cls;
		t = int'(cur_tol);
		cls = CLASS_NONE;
		for (int k = NUM_TONES - 1; k >= 0; k--) begin
			if (int'(freq) >= int'(TONE_TABLE[k]) - t && int'(freq) <= int'(TONE_TABLE[k]) + t)
				cls = CLASS_W'(k);
		end
		return cls;
	endfunction

	// Advance the shadow by one sample; return 1 with the identity when one completes
	function automatic bit decode_sample(input logic [FREQ_W-1:0] freq, output ident_t id);
		logic [CLASS_W-1:0] cls;
		logic [DIGIT_W-1:0] code;
		bit hit;
		bit fired;
		id = '0;
		hit = 1'b0;
		fired = 1'b0;
		cls = tone_class(freq);
		if (cls != last_cls) begin
			last_cls = cls;
			run_cnt = '0;
		end
		// a saturated run counter stops, so a long tone fires only once
		if (run_cnt < RUN_MAX) begin
			run_cnt++;
			hit = (run_cnt == cur_detect);
		end
		if (cls == CLASS_IDLE) begin
			if (hit) begin
				rx_active = 1'b1;
				dig_idx = '0;
				sil_cnt = '0;
			end
		end else if (cls == CLASS_NONE) begin
			if (rx_active && hit)
				rx_active = 1'b0;
		end else if (rx_active && hit && dig_idx < ID_LEN) begin
			code = (cls == CLASS_REPEAT) ? CODE_REPEAT : DIGIT_W'(cls - CLASS_DIGIT0);
			dig_store[dig_idx] = code;
			dig_idx++;
			sil_cnt = '0;
			// a full identity, or a lone repeat tone in first place
			if (dig_idx == ID_LEN || dig_store[0] == CODE_REPEAT) begin
				for (int j = 0; j < OUT_DIGITS; j++)
					id.digit[j] = (j < dig_idx) ? dig_store[j] : '0;
				id.count = dig_idx;
				rx_active = 1'b0;
				fired = 1'b1;
			end
		end
		// silence counts only once a digit is stored; it also saturates
		if (rx_active && dig_idx != 0 && sil_cnt < SILENCE_MAX) begin
			sil_cnt++;
			if (sil_cnt == cur_timeout)
				rx_active = 1'b0;
		end
		return fired;
	endfunction

	function automatic bit pause_roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Sample driver: advance to the next queued sample once the current request is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (sample_q.size() != 0 &&
					!pause_roll(idle_mode == RX_SLOW ? 7 : idle_mode == TX_SLOW ? 67 : 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= sample_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Identity sink: random back-pressure, forced low during the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !rx_hold &&
				!pause_roll(idle_mode == RX_SLOW ? 67 : idle_mode == TX_SLOW ? 7 : 0);
		end
	end

	task automatic flag_field(input string name, input int want, input int got);
		errors++;
		if (errors <= 10)
			$display("ERROR: identity %0d %s expected %0d got %0d", idents_out, name, want, got);
	endtask

	// Monitor: predict on every accepted sample first, then check any accepted identity
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				samples_in++;
				if (decode_sample(s_tdata, id_pred))
					ident_q.push_back(id_pred);
			end
			if (m_tvalid && m_tready) begin
				idents_out++;
				id_got.count = m_tdata[26:24];
				for (int j = 0; j < OUT_DIGITS; j++)
					id_got.digit[j] = m_tdata[DIGIT_W*j +: DIGIT_W];
				if (m_tdata[31:27] != '0)
					flag_field("padding", 0, int'(m_tdata[31:27]));
				if (ident_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: identity %0d arrived unpredicted, data %h", idents_out,
							m_tdata);
				end else begin
					id_want = ident_q.pop_front();
					if (id_got.count != id_want.count)
						flag_field("digit_count", int'(id_want.count), int'(id_got.count));
					for (int j = 0; j < OUT_DIGITS; j++) begin
						if (id_got.digit[j] != id_want.digit[j])
							flag_field($sformatf("id_digit_%0d", j), int'(id_want.digit[j]),
								int'(id_got.digit[j]));
					end
				end
			end
		end
	end

	// Register write; the shadow takes the masked value on the accepting edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DETECT_RUN:  cur_detect = val[RUN_W-1:0];
			REG_TIMEOUT_RUN: cur_timeout = val[SIL_W-1:0];
			REG_TOLERANCE:   cur_tol = val[TOL_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	task automatic set_regs(input int detect, input int timeout, input int tol);
		write_reg(REG_DETECT_RUN, CFG_DATA_W'(detect));
		write_reg(REG_TIMEOUT_RUN, CFG_DATA_W'(timeout));
		write_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
	endtask

	// Wait until every sample is in and every identity out, then let the pipeline empty
	task automatic drain();
		do @(negedge clk); while (sample_q.size() != 0 || s_tvalid || ident_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// A frequency inside the window of one class, edges included
	function automatic logic [FREQ_W-1:0] tone_sample(input int cls);
		int c, t, r;
		c = int'(TONE_TABLE[cls]);
		t = int'(cur_tol);
		r = $urandom_range(0, 7);
		if (r == 0)
			return FREQ_W'(c - t);
		if (r == 1)
			return FREQ_W'(c + t);
		return FREQ_W'(c - t + int'($urandom_range(0, 2 * t)));
	endfunction

	task automatic queue_raw(input logic [FREQ_W-1:0] freq);
		sample_q.push_back(freq);
		queued++;
	endtask

	task automatic queue_tone(input int cls, input int n);
		repeat (n) queue_raw(tone_sample(cls));
	endtask

	// Run length for one tone: at or just past the detect point, or short when it cannot be reached
	function automatic int hold_len();
		if (cur_detect == 0 || cur_detect > 16)
			return $urandom_range(1, 4);
		return int'(cur_detect) + int'($urandom_range(0, 1));
	endfunction

	// Idle, then digits with no class twice in a row; a cut one ends early, often in noise
	task automatic queue_identity(input bit complete);
		int prev, cls, ndig;
		queue_tone(CLASS_IDLE, hold_len());
		prev = CLASS_IDLE;
		ndig = complete ? ID_LEN : $urandom_range(1, ID_LEN - 1);
		for (int k = 0; k < ndig; k++) begin
			if (k == 0 && $urandom_range(0, 7) == 0) begin
				cls = CLASS_REPEAT;
			end else begin
				do cls = $urandom_range(CLASS_REPEAT, NUM_TONES - 1); while (cls == prev);
			end
			queue_tone(cls, hold_len());
			prev = cls;
		end
		if (!complete && $urandom_range(0, 1))
			repeat (hold_len()) queue_raw(FREQ_W'($urandom_range(13000, 65535)));
	endtask

	task automatic random_phase(input int n);
		int start, r;
		start = queued;
		while (queued - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				queue_identity(1'b1);
			end else if (r < 85) begin
				queue_identity(1'b0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1))
						queue_raw(FREQ_W'($urandom()));
					else
						queue_tone($urandom_range(0, NUM_TONES - 1), 1);
				end
			end
		end
	endtask

	// Long output hold-off once the pressure phase has a result in flight
	initial begin
		wait (pressure_go);
		do @(posedge clk); while (!m_tvalid);
		rx_hold <= 1'b1;
		repeat (STALL_LEN) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : stimulus
		int k;
		for (k = 0; k < ID_LEN; k++)
			dig_store[k] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: field extremes and the idle window edges, nothing can be detected
		queue_raw(16'h0000);
		queue_raw(16'hFFFF);
		queue_raw(FREQ_W'(int'(TONE_TABLE[CLASS_IDLE]) - 150));
		queue_raw(FREQ_W'(int'(TONE_TABLE[CLASS_IDLE]) + 150));
		queue_raw(FREQ_W'(int'(TONE_TABLE[CLASS_IDLE]) - 151));
		queue_raw(FREQ_W'(int'(TONE_TABLE[CLASS_IDLE]) + 151));
		drain();

		// Single-sample detect, exact tones, no timeout
		set_regs(1, 0, 0);
		@(negedge clk);
		// lone repeat tone gives a one-digit identity
		queue_tone(CLASS_IDLE, 1);
		queue_tone(CLASS_REPEAT, 1);
		// repeat tone after the first digit is stored as a digit
		queue_tone(CLASS_IDLE, 1);
		for (k = 0; k < 5; k++)
			queue_tone(CLASS_DIGIT0 + k, 1);
		queue_tone(CLASS_REPEAT, 1);
		// out-of-table tone aborts; the next digit finds the block not receiving
		queue_tone(CLASS_IDLE, 1);
		queue_tone(CLASS_DIGIT0 + 5, 1);
		queue_raw(16'h0000);
		queue_tone(CLASS_DIGIT0 + 6, 1);
		// idle mid-identity restarts it
		queue_tone(CLASS_IDLE, 1);
		queue_tone(CLASS_DIGIT0 + 7, 1);
		queue_tone(CLASS_IDLE, 1);
		for (k = 9; k < 15; k++)
			queue_tone(CLASS_DIGIT0 + k, 1);
		drain();
		write_reg(REG_UNUSED, 16'hFFFF);

		// Masked writes; one digit held long with no timeout, then five more
		set_regs(16'h1001, 0, 16'hFFFF);
		@(negedge clk);
		queue_raw(TONE_TABLE[CLASS_IDLE]);
		repeat (LONG_HOLD) queue_raw(16'd3133);
		queue_raw(16'd9798);
		queue_raw(16'd7674);
		queue_raw(16'd6010);
		queue_raw(16'd4708);
		queue_raw(16'd3133);
		drain();

		// Random identities, receiver slow
		set_regs(1, 40, 120);
		@(negedge clk);
		random_phase(200);
		drain();
		// overlapping windows: earlier table entries shadow later ones
		set_regs(2, 30, 1000);
		@(negedge clk);
		random_phase(100);
		drain();

		// Sender slow; short timeout cuts some identities
		set_regs(2, 12, 60);
		@(negedge clk);
		idle_mode = TX_SLOW;
		random_phase(200);
		drain();
		// timeout of one sample: only a lone repeat can finish
		set_regs(1, 1, 0);
		@(negedge clk);
		random_phase(60);
		drain();

		// No gaps on either side, with the long output hold-off
		set_regs(1, 65535, 130);
		@(negedge clk);
		idle_mode = NO_IDLE;
		pressure_go = 1'b1;
		random_phase(200);
		drain();

		// Zero and maximum detect runs: nothing may come out
		set_regs(0, 50, 100);
		@(negedge clk);
		queue_identity(1'b1);
		queue_identity(1'b1);
		drain();
		write_reg(REG_DETECT_RUN, 16'hFFFF);
		@(negedge clk);
		queue_identity(1'b1);

		for (k = 0; k < 4000 && (sample_q.size() != 0 || s_tvalid || ident_q.size() != 0); k++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (ident_q.size() != 0) begin
			errors += ident_q.size();
			$display("ERROR: %0d predicted identities never arrived", ident_q.size());
		end

		$display("Run covered %0d samples, %0d identities and %0d register writes,",
			samples_in, idents_out, reg_writes);
		$display("including masked writes, timeouts, overlapping windows and an output stall.");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog, several times the slowest correct run
	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
src/stid_pkg.sv
src/stid_front.sv
src/stid_evq.sv
src/stid_back.sv
src/sequential_tone_id_decoder.sv
test/sequential_tone_id_decoder_tb.sv
